FILE: rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the sampled Manchester receiver.
// Holds the register map, the register reset values and the byte constants.
// ----------------------------------------------------------------------------
package msr_pkg;

    // Register map: register i lies at byte address 4*i.
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_HALF_PERIOD  = 2'd1,
        REG_START_OFFSET = 2'd2,
        REG_TIMEOUT      = 2'd3
    } cfg_reg_t;

    // Configuration field widths and reset values.
    localparam int THRESHOLD_BITS = 12;
    localparam int TICKS_BITS     = 16;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET    = 12'd2048;
    localparam logic [TICKS_BITS-1:0]     HALF_PERIOD_RESET  = 16'd100;
    localparam logic [TICKS_BITS-1:0]     START_OFFSET_RESET = 16'd50;
    localparam logic [TICKS_BITS-1:0]     TIMEOUT_RESET      = 16'd2000;

    // Byte assembly.
    localparam int            BYTE_BITS      = 8;
    localparam logic [2:0]    LAST_BIT_INDEX = 3'd7;

endpackage

FILE: rtl/manchester_sampled_receiver_core.sv
// ----------------------------------------------------------------------------
// manchester_sampled_receiver_core: sampled Manchester receiver.
// Thresholds converter samples once per half period after sync, turns sample
// pairs into bits, packs them MSB first into bytes and ends a frame on timeout.
// ----------------------------------------------------------------------------
// The block takes one converter sample per cycle while in_ready is high and
// gives at most one result word per sample: a received byte, or a frame end word
// with data zero. Each sample is processed in the cycle it is accepted; its
// result sits in the output register from the next cycle on, or in the skid
// register if the output word is held. in_ready drops only when both hold words
// not yet taken, so a slow consumer stalls the input only after two pending
// results. The user must write configuration through the APB port only while
// the block is idle; the block does not enforce this. pready is always high.
module manchester_sampled_receiver_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [msr_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [msr_pkg::DATA_BITS-1:0]    pwdata,
    output logic [msr_pkg::DATA_BITS-1:0]    prdata,
    output logic                             pready,

    // Sample input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic                             sync_end,

    // Result output channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [msr_pkg::BYTE_BITS-1:0]    data,
    output logic                             frame_end
);

    import msr_pkg::*;

    // Only the low bits that both the field and the sample width allow count.
    localparam int EFF_BITS = (SAMPLE_BITS < THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Clamp a 16-bit register value into the counter width.
    function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [TICKS_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        if (32'(v) > 32'(COUNT_MAX))
        begin
            r = COUNT_MAX;
        end
        else
        begin
            r = COUNT_BITS'(v);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [TICKS_BITS-1:0]  half_period_reg;
    logic [TICKS_BITS-1:0]  start_offset_reg;
    logic [TICKS_BITS-1:0]  timeout_reg;
    logic                   cfg_write;
    cfg_reg_t               cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= SAMPLE_BITS'(THRESHOLD_RESET[EFF_BITS-1:0]);
            half_period_reg  <= HALF_PERIOD_RESET;
            start_offset_reg <= START_OFFSET_RESET;
            timeout_reg      <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_THRESHOLD:    threshold_reg    <= SAMPLE_BITS'(pwdata[EFF_BITS-1:0]);
                REG_HALF_PERIOD:  half_period_reg  <= pwdata[TICKS_BITS-1:0];
                REG_START_OFFSET: start_offset_reg <= pwdata[TICKS_BITS-1:0];
                REG_TIMEOUT:      timeout_reg      <= pwdata[TICKS_BITS-1:0];
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (cfg_sel)
            REG_THRESHOLD:    prdata = DATA_BITS'(threshold_reg);
            REG_HALF_PERIOD:  prdata = DATA_BITS'(half_period_reg);
            REG_START_OFFSET: prdata = DATA_BITS'(start_offset_reg);
            REG_TIMEOUT:      prdata = DATA_BITS'(timeout_reg);
        endcase
    end

    // ------------------------------------------------------------------------
    // Receiver state.
    // ------------------------------------------------------------------------
    logic                  receiving_reg,   receiving_next;
    logic [COUNT_BITS-1:0] tick_reg,        tick_next;
    logic [COUNT_BITS-1:0] idle_reg,        idle_next;
    logic                  second_half_reg, second_half_next;
    logic                  first_level_reg, first_level_next;
    logic [2:0]            bits_reg,        bits_next;
    logic [BYTE_BITS-1:0]  shift_reg,       shift_next;

    // Result of the current sample.
    logic                  res_valid;
    logic [BYTE_BITS-1:0]  res_data;
    logic                  res_frame_end;

    logic                  in_fire;
    logic [COUNT_BITS-1:0] idle_inc;
    logic [COUNT_BITS-1:0] reload_ticks;
    logic [COUNT_BITS-1:0] start_ticks;
    logic [SAMPLE_BITS-1:0] sample_eff;
    logic                  level;
    logic [BYTE_BITS-1:0]  shifted;

    assign in_fire    = in_valid && in_ready;
    assign idle_inc   = (idle_reg == COUNT_MAX) ? idle_reg : idle_reg + 1'b1;
    assign reload_ticks = (half_period_reg == '0) ? '0
                        : clamp_count(half_period_reg - 1'b1);
    assign start_ticks  = (start_offset_reg == '0) ? '0
                        : clamp_count(start_offset_reg - 1'b1);
    assign sample_eff = SAMPLE_BITS'(sample[EFF_BITS-1:0]);
    assign level      = (sample_eff >= threshold_reg);
    assign shifted    = {shift_reg[BYTE_BITS-2:0], level};

    // Next state and result of one accepted sample.
    always_comb
    begin
        receiving_next   = receiving_reg;
        tick_next        = tick_reg;
        idle_next        = idle_reg;
        second_half_next = second_half_reg;
        first_level_next = first_level_reg;
        bits_next        = bits_reg;
        shift_next       = shift_reg;
        res_valid        = 1'b0;
        res_data         = '0;
        res_frame_end    = 1'b0;

        if (in_fire)
        begin
            if (!receiving_reg)
            begin
                // Waiting for sync: arm the start offset.
                if (sync_end)
                begin
                    receiving_next   = 1'b1;
                    tick_next        = start_ticks;
                    idle_next        = '0;
                    second_half_next = 1'b0;
                    first_level_next = 1'b0;
                    bits_next        = '0;
                    shift_next       = '0;
                end
            end
            else if (tick_reg != '0)
            begin
                // Between sample points.
                idle_next = idle_inc;
                tick_next = tick_reg - 1'b1;
            end
            else
            begin
                tick_next = reload_ticks;
                if (!second_half_reg)
                begin
                    // Bit boundary: check the timeout, else keep the first level.
                    if (32'(idle_inc) > 32'(timeout_reg))
                    begin
                        receiving_next   = 1'b0;
                        idle_next        = '0;
                        tick_next        = '0;
                        first_level_next = 1'b0;
                        bits_next        = '0;
                        shift_next       = '0;
                        res_valid        = 1'b1;
                        res_frame_end    = 1'b1;
                    end
                    else
                    begin
                        idle_next        = idle_inc;
                        first_level_next = level;
                        second_half_next = 1'b1;
                    end
                end
                else
                begin
                    // Second sample: a real transition clears the idle timer.
                    second_half_next = 1'b0;
                    idle_next = (first_level_reg != level) ? '0 : idle_inc;
                    if (bits_reg == LAST_BIT_INDEX)
                    begin
                        res_valid  = 1'b1;
                        res_data   = shifted;
                        bits_next  = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        bits_next  = bits_reg + 1'b1;
                        shift_next = shifted;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            tick_reg        <= '0;
            idle_reg        <= '0;
            second_half_reg <= 1'b0;
            first_level_reg <= 1'b0;
            bits_reg        <= '0;
            shift_reg       <= '0;
        end
        else
        begin
            receiving_reg   <= receiving_next;
            tick_reg        <= tick_next;
            idle_reg        <= idle_next;
            second_half_reg <= second_half_next;
            first_level_reg <= first_level_next;
            bits_reg        <= bits_next;
            shift_reg       <= shift_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output register with a skid word behind it.
    // ------------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [BYTE_BITS-1:0] out_data_reg;
    logic                 out_frame_end_reg;
    logic                 skid_valid_reg;
    logic [BYTE_BITS-1:0] skid_data_reg;
    logic                 skid_frame_end_reg;
    logic                 out_pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign frame_end = out_frame_end_reg;
    assign out_pop   = out_valid_reg && out_ready;

    // Valid flags of the two output words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of the two output words.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_reg      <= skid_data_reg;
                out_frame_end_reg <= skid_frame_end_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_data_reg      <= res_data;
                out_frame_end_reg <= res_frame_end;
            end
            else
            begin
                skid_data_reg      <= res_data;
                skid_frame_end_reg <= res_frame_end;
            end
        end
    end

endmodule
